// ----- rtl/lcdx_pkg.sv -----
// lcdx_pkg: shared types, codes and helpers of the character LCD expander encoder.
// No dependencies; used by every module of the block.
package lcdx_pkg;

  localparam int unsigned NumBeats  = 7;
  localparam int unsigned StepW     = $clog2(NumBeats);
  localparam int unsigned AddrW     = 4;

  localparam logic [7:0] CharFormFeed = 8'h0C;
  localparam logic [7:0] CharNewline  = 8'h0A;
  localparam logic [7:0] CharBack     = 8'h08;

  localparam logic [7:0] CmdClear = 8'h01;
  localparam logic [7:0] CmdLeft  = 8'h10;
  localparam logic [7:0] CmdDdram = 8'h80;

  localparam logic [7:0] BlBit = 8'b0000_1000;
  localparam logic [7:0] EnBit = 8'b0000_0100;
  localparam logic [7:0] RsBit = 8'b0000_0001;

  localparam logic [7:0] ResetSlave   = 8'h4E;
  localparam logic       ResetBacklit = 1'b1;
  localparam logic [2:0] ResetRows    = 3'd2;
  localparam logic [4:0] ResetCols    = 5'd16;

  typedef enum logic [1:0] {
    RegSlave   = 2'd0,
    RegBacklit = 2'd1,
    RegRows    = 2'd2,
    RegCols    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] code;
    logic       rs;
  } cmd_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_address;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [6:0] row_base(input logic [2:0] row);
    logic [6:0] b;
    unique case (row)
      3'd2:    b = 7'h40;
      3'd3:    b = 7'h14;
      3'd4:    b = 7'h54;
      default: b = 7'h00;
    endcase
    return b;
  endfunction

  // Expander write for beats 1..6: nibble, enable strobe, RS and backlight.
  function automatic logic [7:0] data_beat(input logic [StepW-1:0] step,
                                           input cmd_t cmd, input logic bl);
    logic [3:0] nib;
    logic [7:0] b;
    nib = (step <= StepW'(3)) ? cmd.code[7:4] : cmd.code[3:0];
    b = {nib, 4'h0};
    if (cmd.rs) b = b | RsBit;
    if (bl) b = b | BlBit;
    if (step == StepW'(2) || step == StepW'(5)) b = b | EnBit;
    return b;
  endfunction

endpackage

// ----- rtl/lcdx_char_if.sv -----
// lcdx_char_if: input channel carrying one character byte per beat.
// Depends on nothing.
interface lcdx_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ----- rtl/lcdx_bus_if.sv -----
// lcdx_bus_if: output channel carrying one I2C bus byte per beat.
// Depends on nothing.
interface lcdx_bus_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       is_address;
  logic       last;

  modport source (output valid, output bus_byte, output is_address, output last, input ready);
  modport sink   (input valid, input bus_byte, input is_address, input last, output ready);
endinterface

// ----- rtl/lcdx_front.sv -----
// lcdx_front: accepts characters, classifies them into LCD commands or data, tracks the row.
// Depends on lcdx_pkg and lcdx_char_if.
module lcdx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcdx_char_if.sink           char_i,
  input  logic [2:0]          total_rows_i,
  input  logic [4:0]          total_columns_i,
  input  lcdx_pkg::q_status_t q_status_i,
  output logic                push_o,
  output lcdx_pkg::cmd_t      cmd_o
);

  logic [2:0] row_q, row_d;
  logic [3:0] next_row;
  logic [3:0] new_row;
  logic [2:0] tgt_row;
  logic       col;
  logic [6:0] ddram;

  assign char_i.ready = !q_status_i.full;
  assign push_o       = char_i.valid && !q_status_i.full;

  always_comb begin
    next_row = {1'b0, row_q} + 4'd1;
    new_row  = (next_row > {1'b0, total_rows_i}) ? 4'd1 : next_row;
    tgt_row  = (new_row > {1'b0, total_rows_i}) ? total_rows_i : new_row[2:0];
    col      = (total_columns_i != 5'd0);
    ddram    = lcdx_pkg::row_base(tgt_row) + {6'd0, col} + 7'h7F;
  end

  always_comb begin
    row_d = row_q;
    cmd_o = '{code: char_i.char_code, rs: 1'b1};
    priority if (char_i.char_code == lcdx_pkg::CharFormFeed) begin
      row_d = 3'd1;
      cmd_o = '{code: lcdx_pkg::CmdClear, rs: 1'b0};
    end else if (char_i.char_code == lcdx_pkg::CharNewline) begin
      row_d = new_row[2:0];
      cmd_o = '{code: lcdx_pkg::CmdDdram | {1'b0, ddram}, rs: 1'b0};
    end else if (char_i.char_code == lcdx_pkg::CharBack) begin
      cmd_o = '{code: lcdx_pkg::CmdLeft, rs: 1'b0};
    end else begin
      cmd_o = '{code: char_i.char_code, rs: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 3'd1;
    end else if (push_o) begin
      row_q <= row_d;
    end
  end

endmodule

// ----- rtl/lcdx_queue.sv -----
// lcdx_queue: two-entry command queue between front and back.
// Depends on lcdx_pkg.
module lcdx_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lcdx_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output lcdx_pkg::cmd_t      cmd_o,
  output lcdx_pkg::q_status_t status_o
);

  lcdx_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign cmd_o          = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
    end
  end

endmodule

// ----- rtl/lcdx_back.sv -----
// lcdx_back: serializes each queued command into a seven-byte expander transaction.
// Depends on lcdx_pkg and lcdx_bus_if.
module lcdx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdx_pkg::q_status_t q_status_i,
  input  lcdx_pkg::cmd_t      cmd_i,
  input  logic [7:0]          slave_address_i,
  input  logic                backlight_on_i,
  output logic                pop_o,
  lcdx_bus_if.source          bus_o
);

  localparam logic [lcdx_pkg::StepW-1:0] LastStep = lcdx_pkg::StepW'(lcdx_pkg::NumBeats - 1);

  lcdx_pkg::cmd_t                cur_q;
  logic [lcdx_pkg::StepW-1:0]    step_q;
  logic                          active_q;
  logic                          out_valid_q;
  lcdx_pkg::beat_t               out_q;
  logic                          load;

  assign load  = !out_valid_q || bus_o.ready;
  assign pop_o = load && !active_q && !q_status_i.empty;

  assign bus_o.valid      = out_valid_q;
  assign bus_o.bus_byte   = out_q.bus_byte;
  assign bus_o.is_address = out_q.is_address;
  assign bus_o.last       = out_q.last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (active_q) begin
        out_q <= '{bus_byte:   lcdx_pkg::data_beat(step_q, cur_q, backlight_on_i),
                   is_address: 1'b0,
                   last:       (step_q == LastStep)};
      end else if (pop_o) begin
        cur_q <= cmd_i;
        out_q <= '{bus_byte: slave_address_i, is_address: 1'b1, last: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      if (active_q) begin
        out_valid_q <= 1'b1;
        step_q      <= step_q + lcdx_pkg::StepW'(1);
        if (step_q == LastStep) active_q <= 1'b0;
      end else if (pop_o) begin
        out_valid_q <= 1'b1;
        active_q    <= 1'b1;
        step_q      <= lcdx_pkg::StepW'(1);
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/char_lcd_i2c_expander_encoder.sv -----
// char_lcd_i2c_expander_encoder: top level with APB register file, front, queue and back.
// Depends on lcdx_pkg, lcdx_char_if, lcdx_bus_if, lcdx_front, lcdx_queue, lcdx_back.
//
// Each accepted character gives one transaction of seven bus bytes: the slave address
// (is_address high), then three expander writes for the high nibble and three for the
// low nibble, the last flagged by last. The back end sends one byte per cycle while the
// output is ready and starts the next queued character only once the last byte of the
// current transaction is loaded. A two-entry queue lets up to two characters be taken
// ahead while a transaction is on the bus. Registers sit at byte addresses 0, 4, 8, 12
// (slave address, backlight, rows, columns) and should only be written while idle.
module char_lcd_i2c_expander_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lcdx_char_if.sink                   char_i,
  lcdx_bus_if.source                  bus_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcdx_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [7:0] slave_q;
  logic       backlit_q;
  logic [2:0] rows_q;
  logic [4:0] cols_q;
  logic       wr_en;
  lcdx_pkg::reg_idx_e reg_idx;

  lcdx_pkg::q_status_t q_status;
  lcdx_pkg::cmd_t      push_cmd, head_cmd;
  logic                push, pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = lcdx_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      lcdx_pkg::RegSlave:   prdata = {24'd0, slave_q};
      lcdx_pkg::RegBacklit: prdata = {31'd0, backlit_q};
      lcdx_pkg::RegRows:    prdata = {29'd0, rows_q};
      lcdx_pkg::RegCols:    prdata = {27'd0, cols_q};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q   <= lcdx_pkg::ResetSlave;
      backlit_q <= lcdx_pkg::ResetBacklit;
      rows_q    <= lcdx_pkg::ResetRows;
      cols_q    <= lcdx_pkg::ResetCols;
    end else if (wr_en) begin
      unique case (reg_idx)
        lcdx_pkg::RegSlave:   slave_q   <= pwdata[7:0];
        lcdx_pkg::RegBacklit: backlit_q <= pwdata[0];
        lcdx_pkg::RegRows:    rows_q    <= pwdata[2:0];
        lcdx_pkg::RegCols:    cols_q    <= pwdata[4:0];
        default:              slave_q   <= slave_q;
      endcase
    end
  end

  lcdx_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_i          (char_i),
    .total_rows_i    (rows_q),
    .total_columns_i (cols_q),
    .q_status_i      (q_status),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  lcdx_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  lcdx_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .cmd_i           (head_cmd),
    .slave_address_i (slave_q),
    .backlight_on_i  (backlit_q),
    .pop_o           (pop),
    .bus_o           (bus_o)
  );

`ifndef SYNTH
  a_addr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bus_o.valid && bus_o.is_address |-> !bus_o.last && bus_o.bus_byte == slave_q)
    else $error("address beat malformed");

  a_rw_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bus_o.valid && !bus_o.is_address |-> !bus_o.bus_byte[1]
      && bus_o.bus_byte[3] == backlit_q)
    else $error("expander write has RW set or wrong backlight");

  a_last_then_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bus_o.valid && bus_o.ready && bus_o.last |=> !bus_o.valid || bus_o.is_address)
    else $error("transaction did not restart with address");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");
`endif

endmodule

// ----- tb/sv/tb_char_lcd_i2c_expander_encoder.sv -----
// Self-checking testbench for char_lcd_i2c_expander_encoder: streams characters under
// several register settings and checks every I2C bus beat against an in-bench predictor.
// Depends on lcdx_pkg, lcdx_char_if, lcdx_bus_if and the encoder RTL.
`timescale 1ns / 100ps

module tb_char_lcd_i2c_expander_encoder;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SegItems   = 53;
  localparam int unsigned NumSegs    = 9;
  localparam int unsigned DrainWait  = 12;

  class lcd_beat_scoreboard;
    logic [7:0]       slave_addr;
    logic             backlit;
    logic [2:0]       rows;
    logic [4:0]       cols;
    logic [2:0]       cur_row;
    lcdx_pkg::beat_t  expected_beats[$];
    int unsigned      mismatches;

    function new();
      slave_addr = lcdx_pkg::ResetSlave;
      backlit    = lcdx_pkg::ResetBacklit;
      rows       = lcdx_pkg::ResetRows;
      cols       = lcdx_pkg::ResetCols;
      cur_row    = 3'd1;
      mismatches = 0;
    endfunction

    function void set_reg(input lcdx_pkg::reg_idx_e idx, input logic [31:0] val);
      case (idx)
        lcdx_pkg::RegSlave:   slave_addr = val[7:0];
        lcdx_pkg::RegBacklit: backlit = val[0];
        lcdx_pkg::RegRows:    rows = val[2:0];
        lcdx_pkg::RegCols:    cols = val[4:0];
        default:    ;
      endcase
    endfunction

    function void note_char(input logic [7:0] c);
      logic [7:0]      code;
      logic            rs;
      logic [3:0]      nxt;
      logic [2:0]      tgt;
      logic [6:0]      base;
      logic [6:0]      col;
      logic [3:0]      nib;
      lcdx_pkg::beat_t bt;
      rs = 1'b0;
      case (c)
        lcdx_pkg::CharFormFeed: begin
          code = lcdx_pkg::CmdClear;
          cur_row = 3'd1;
        end
        lcdx_pkg::CharNewline: begin
          nxt = {1'b0, cur_row} + 4'd1;
          if (nxt > {1'b0, rows}) nxt = 4'd1;
          cur_row = nxt[2:0];
          tgt = (nxt > {1'b0, rows}) ? rows : nxt[2:0];
          case (tgt)
            3'd2:    base = 7'h40;
            3'd3:    base = 7'h14;
            3'd4:    base = 7'h54;
            default: base = 7'h00;
          endcase
          col = (cols == 5'd0) ? 7'd0 : 7'd1;
          // 7-bit sum wraps below zero when the column count and the row base are both zero
          code = lcdx_pkg::CmdDdram | {1'b0, base + col - 7'd1};
        end
        lcdx_pkg::CharBack: code = lcdx_pkg::CmdLeft;
        default: begin
          code = c;
          rs = 1'b1;
        end
      endcase
      bt.bus_byte = slave_addr;
      bt.is_address = 1'b1;
      bt.last = 1'b0;
      expected_beats.push_back(bt);
      for (int k = 1; k <= 6; k++) begin
        nib = (k <= 3) ? code[7:4] : code[3:0];
        bt.bus_byte = {nib, 4'h0};
        if (rs) bt.bus_byte = bt.bus_byte | lcdx_pkg::RsBit;
        if (backlit) bt.bus_byte = bt.bus_byte | lcdx_pkg::BlBit;
        if (k == 2 || k == 5) bt.bus_byte = bt.bus_byte | lcdx_pkg::EnBit;
        bt.is_address = 1'b0;
        bt.last = (k == 6);
        expected_beats.push_back(bt);
      end
    endfunction

    function void check_beat(input logic [7:0] got_byte, input logic got_adr,
                             input logic got_last);
      lcdx_pkg::beat_t exp_bt;
      if (expected_beats.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: byte %02h adr %0b last %0b", got_byte, got_adr,
                   got_last);
        mismatches++;
      end else begin
        exp_bt = expected_beats.pop_front();
        if (exp_bt.bus_byte !== got_byte || exp_bt.is_address !== got_adr ||
            exp_bt.last !== got_last) begin
          if (mismatches < 10)
            $display("beat mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                     exp_bt.bus_byte, exp_bt.is_address, exp_bt.last,
                     got_byte, got_adr, got_last);
          mismatches++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_beats.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [lcdx_pkg::AddrW-1:0]  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  int unsigned                 src_idle_pct;
  int unsigned                 snk_idle_pct;
  int unsigned                 cycle_cnt;
  lcd_beat_scoreboard          sb;

  logic [7:0] opening_chars [25] = '{
    8'h00, 8'hFF, lcdx_pkg::CharFormFeed, lcdx_pkg::CharNewline,
    lcdx_pkg::CharNewline, lcdx_pkg::CharNewline, lcdx_pkg::CharBack,
    8'h41, 8'h7F, 8'h80, 8'h0B, 8'h0D, 8'h09, 8'h07, 8'h55, 8'hAA,
    lcdx_pkg::CharNewline, lcdx_pkg::CharFormFeed, lcdx_pkg::CharNewline,
    lcdx_pkg::CharBack, 8'h0F, 8'hF0, 8'h20, lcdx_pkg::CharFormFeed, 8'h01
  };

  lcdx_char_if char_if ();
  lcdx_bus_if  bus_if ();

  char_lcd_i2c_expander_encoder DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .bus_o   (bus_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    bus_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && bus_if.valid && bus_if.ready)
      sb.check_beat(bus_if.bus_byte, bus_if.is_address, bus_if.last);
  end

  task automatic send_char(input logic [7:0] code);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.char_code <= code;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    sb.note_char(code);
  endtask

  task automatic apb_write(input lcdx_pkg::reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic wait_idle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic program_settings(input int unsigned seg);
    logic [31:0] sa, bl, nr, nc;
    case (seg)
      1: begin sa = 32'h00; bl = 32'd0; nr = 32'd1; nc = 32'd1;  end
      2: begin sa = 32'hFF; bl = 32'd1; nr = 32'd4; nc = 32'd20; end
      3: begin sa = 32'h4E; bl = 32'd1; nr = 32'd0; nc = 32'd0;  end
      4: begin sa = 32'hA5; bl = 32'd0; nr = 32'd7; nc = 32'd31; end
      default: begin
        sa = $urandom_range(0, 255);
        bl = $urandom_range(0, 1);
        nr = $urandom_range(0, 7);
        nc = $urandom_range(0, 31);
      end
    endcase
    apb_write(lcdx_pkg::RegSlave, sa);
    apb_write(lcdx_pkg::RegBacklit, bl);
    apb_write(lcdx_pkg::RegRows, nr);
    apb_write(lcdx_pkg::RegCols, nc);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return lcdx_pkg::CharNewline;
    if (r < 20) return lcdx_pkg::CharFormFeed;
    if (r < 27) return lcdx_pkg::CharBack;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    sb = new();
    src_idle_pct = 34;
    snk_idle_pct = 62;
    rst_ni <= 1'b0;
    char_if.valid <= 1'b0;
    char_if.char_code <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned seg = 0; seg < NumSegs; seg++) begin
      case (seg / 3)
        0:       begin src_idle_pct = 34; snk_idle_pct = 62; end
        1:       begin src_idle_pct = 62; snk_idle_pct = 34; end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      endcase
      if (seg > 0) begin
        wait_idle();
        program_settings(seg);
      end
      if (seg == 0) begin
        foreach (opening_chars[i]) send_char(opening_chars[i]);
      end else begin
        repeat (SegItems) send_char(pick_char());
      end
      char_if.valid <= 1'b0;
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
